>>> rtl/sorted_timer_queue_defines.svh
// Assertion macros shared by the sorted timer queue modules.
`ifndef SORTED_TIMER_QUEUE_DEFINES_SVH
`define SORTED_TIMER_QUEUE_DEFINES_SVH

// Checks that a condition holds at every clock edge outside reset.
`define STQ_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define STQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/stq_pkg.sv
// Package with the types, codes and helper functions of the sorted timer queue.
`timescale 1ns / 1ps

package stq_pkg;

    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_ONESHOT  = 3'd1;
    localparam logic [2:0] CMD_PERIODIC = 3'd2;
    localparam logic [2:0] CMD_STOP     = 3'd3;
    localparam logic [2:0] CMD_READ     = 3'd4;

    localparam logic [1:0] EV_ACK      = 2'd0;
    localparam logic [1:0] EV_ONESHOT  = 2'd1;
    localparam logic [1:0] EV_PERIODIC = 2'd2;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    localparam int          MAX_RES   = 16;
    localparam logic [4:0]  MAX_RES_V = 5'(MAX_RES);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_UL_RD,
        S_UL_CHK,
        S_IN_INIT,
        S_IN_RD,
        S_IN_CHK,
        S_RESP,
        S_RD_REM,
        S_T_HEAD,
        S_T_HCHK,
        S_T_FLUSH,
        S_T_TAKE,
        S_T_RELOAD,
        S_T_END
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_TICK_START,
        OP_ARM_SETUP,
        OP_STOP_SETUP,
        OP_READ_SETUP,
        OP_UL_READ,
        OP_UL_STEP,
        OP_UL_FIN,
        OP_IN_START,
        OP_IN_READ,
        OP_IN_SHIFT,
        OP_IN_FIN,
        OP_HEAD_READ,
        OP_TAKE,
        OP_RELOAD,
        OP_LOAD_ACK,
        OP_LOAD_REM,
        OP_LOAD_PEND,
        OP_LOAD_IDLE_ACK
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   in_ready;
        logic   err;
        logic   last;
    } t_ctrl_cmd;

    typedef struct packed {
        logic       in_valid;
        logic [2:0] cmd;
        logic       id_ok;
        logic       active_id;
        logic       delay_zero;
        logic       period_zero;
        logic       count_zero;
        logic       nres_max;
        logic       ul_done;
        logic       in_at_head;
        logic       in_shift;
        logic       head_due;
        logic       per_nz;
        logic       pend_v;
        logic       out_full;
    } t_dp_sts;

    // True when time a lies before time b on the wrapping 32-bit scale.
    function automatic logic f_before(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] diff;
        diff = a - b;
        return diff[31];
    endfunction

endpackage

>>> rtl/stq_if.sv
// Handshake interfaces for the command and result channels.
`timescale 1ns / 1ps

interface stq_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [3:0]  timer_id;
    logic [30:0] delay;
    logic [30:0] period;
    logic        idle;

    modport source (output valid, command, timer_id, delay, period, idle, input ready);
    modport sink (input valid, command, timer_id, delay, period, idle, output ready);
endinterface

interface stq_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_res;
    logic [3:0]  slot;
    logic        status;
    logic [30:0] remaining;
    logic [31:0] now_ticks;
    logic [31:0] idle_total;
    logic        last;

    modport source (output valid, event_res, slot, status, remaining, now_ticks, idle_total,
                    last, input ready);
    modport sink (input valid, event_res, slot, status, remaining, now_ticks, idle_total,
                  last, output ready);
endinterface

>>> rtl/stq_datapath.sv
// Datapath of the timer queue: counters, slot tables, ordered list and result register.
`timescale 1ns / 1ps
`include "sorted_timer_queue_defines.svh"

module stq_datapath
    import stq_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ctrl_cmd i_cmd,
    output t_dp_sts   o_sts,
    stq_cmd_if.sink   i_cmd_if,
    stq_res_if.source o_res_if
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    logic [2:0]  r_cmd;
    logic [3:0]  r_id;
    logic [30:0] r_delay;
    logic [30:0] r_period;
    logic        r_idle_in;

    logic [31:0] r_now;
    logic [31:0] r_idle;
    logic [SLOTS-1:0] r_active;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_ptr;
    logic          r_shifting;
    logic [SW-1:0] r_slot;
    logic [31:0]   r_exp;
    logic [31:0]   r_eold;
    logic [30:0]   r_per;
    logic [4:0]    r_nres;
    logic          r_pend_v;
    logic [1:0]    r_pend_ev;
    logic [SW-1:0] r_pend_slot;

    logic [SW-1:0] lmem_slot [SLOTS];
    logic [31:0]   lmem_exp  [SLOTS];
    logic [SW-1:0] r_lrd_slot;
    logic [31:0]   r_lrd_exp;
    logic [31:0]   smem_exp  [SLOTS];
    logic [30:0]   smem_per  [SLOTS];
    logic [31:0]   r_srd_exp;
    logic [30:0]   r_srd_per;

    logic          r_ovalid;
    logic [1:0]    r_oev;
    logic [3:0]    r_oslot;
    logic          r_ostat;
    logic [30:0]   r_orem;
    logic [31:0]   r_onow;
    logic [31:0]   r_oidle;
    logic          r_olast;

    logic          l_we;
    logic [SW-1:0] l_waddr;
    logic [SW-1:0] l_wslot;
    logic [31:0]   l_wexp;
    logic          l_re;
    logic [SW-1:0] l_raddr;
    logic          s_re;
    logic [SW-1:0] s_raddr;

    logic [SW-1:0] id_idx;
    logic [30:0]   delay_min;
    logic [31:0]   reload_ne;
    logic [31:0]   reload_exp;
    logic [31:0]   rem_diff;
    logic [CW:0]   ptr_next;
    logic          out_take;

    assign id_idx     = SW'(r_id);
    assign delay_min  = (r_delay == 31'd0) ? 31'd1 : r_delay;
    assign reload_ne  = r_eold + {1'b0, r_srd_per};
    assign reload_exp = f_before(r_now, reload_ne) ? reload_ne : (r_now + 32'd1);
    assign rem_diff   = r_srd_exp - r_now;
    assign ptr_next   = {1'b0, r_ptr} + (CW + 1)'(1);
    assign out_take   = r_ovalid && o_res_if.ready;

    assign i_cmd_if.ready = i_cmd.in_ready;

    always_comb begin
        o_sts.in_valid    = i_cmd_if.valid;
        o_sts.cmd         = r_cmd;
        o_sts.id_ok       = (32'(r_id) < SLOTS);
        o_sts.active_id   = r_active[id_idx];
        o_sts.delay_zero  = (r_delay == 31'd0);
        o_sts.period_zero = (r_period == 31'd0);
        o_sts.count_zero  = (r_count == '0);
        o_sts.nres_max    = (r_nres == MAX_RES_V);
        o_sts.ul_done     = r_shifting ? (ptr_next >= {1'b0, r_count}) : (r_ptr >= r_count);
        o_sts.in_at_head  = (r_ptr == '0);
        o_sts.in_shift    = f_before(r_exp, r_lrd_exp);
        o_sts.head_due    = !f_before(r_now, r_lrd_exp);
        o_sts.per_nz      = (r_srd_per != 31'd0);
        o_sts.pend_v      = r_pend_v;
        o_sts.out_full    = r_ovalid;
    end

    always_comb begin
        l_we    = 1'b0;
        l_waddr = r_ptr[SW-1:0];
        l_wslot = r_lrd_slot;
        l_wexp  = r_lrd_exp;
        l_re    = 1'b0;
        l_raddr = r_ptr[SW-1:0];
        s_re    = 1'b0;
        s_raddr = id_idx;
        case (i_cmd.op)
            OP_UL_READ: begin
                l_re    = 1'b1;
                l_raddr = r_shifting ? SW'(ptr_next) : r_ptr[SW-1:0];
            end
            OP_UL_STEP: begin
                l_we = r_shifting;
            end
            OP_IN_READ: begin
                l_re    = 1'b1;
                l_raddr = SW'(r_ptr - CW'(1));
            end
            OP_IN_SHIFT: begin
                l_we = 1'b1;
            end
            OP_IN_FIN: begin
                l_we    = 1'b1;
                l_wslot = r_slot;
                l_wexp  = r_exp;
            end
            OP_HEAD_READ: begin
                l_re    = 1'b1;
                l_raddr = '0;
            end
            OP_READ_SETUP: begin
                s_re = 1'b1;
            end
            OP_TAKE: begin
                s_re    = 1'b1;
                s_raddr = r_lrd_slot;
            end
            default: begin
                l_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (l_we) begin
            lmem_slot[l_waddr] <= l_wslot;
            lmem_exp[l_waddr]  <= l_wexp;
        end
        if (l_re) begin
            r_lrd_slot <= lmem_slot[l_raddr];
            r_lrd_exp  <= lmem_exp[l_raddr];
        end
        if (i_cmd.op == OP_IN_FIN) begin
            smem_exp[r_slot] <= r_exp;
            smem_per[r_slot] <= r_per;
        end
        if (s_re) begin
            r_srd_exp <= smem_exp[s_raddr];
            r_srd_per <= smem_per[s_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAPTURE: begin
                r_cmd     <= i_cmd_if.command;
                r_id      <= i_cmd_if.timer_id;
                r_delay   <= i_cmd_if.delay;
                r_period  <= i_cmd_if.period;
                r_idle_in <= i_cmd_if.idle;
            end
            OP_ARM_SETUP: begin
                r_slot     <= id_idx;
                r_exp      <= r_now + {1'b0, delay_min};
                r_per      <= (r_cmd == CMD_PERIODIC) ? r_period : 31'd0;
                r_ptr      <= '0;
                r_shifting <= 1'b0;
            end
            OP_STOP_SETUP: begin
                r_slot     <= id_idx;
                r_ptr      <= '0;
                r_shifting <= 1'b0;
            end
            OP_UL_STEP: begin
                if (r_shifting || (r_lrd_slot != r_slot)) begin
                    r_ptr <= CW'(ptr_next);
                end
                if (r_lrd_slot == r_slot) begin
                    r_shifting <= 1'b1;
                end
            end
            OP_IN_START: begin
                r_ptr <= r_count;
            end
            OP_IN_SHIFT: begin
                r_ptr <= r_ptr - CW'(1);
            end
            OP_TAKE: begin
                r_slot <= r_lrd_slot;
                r_eold <= r_lrd_exp;
            end
            OP_RELOAD: begin
                r_per      <= r_srd_per;
                r_exp      <= reload_exp;
                r_ptr      <= '0;
                r_shifting <= 1'b0;
            end
            default: begin
                r_ptr <= r_ptr;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now    <= '0;
            r_idle   <= '0;
            r_active <= '0;
            r_count  <= '0;
            r_nres   <= '0;
            r_pend_v <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_TICK_START: begin
                    r_now    <= r_now + 32'd1;
                    r_idle   <= r_idle + {31'd0, r_idle_in};
                    r_nres   <= '0;
                    r_pend_v <= 1'b0;
                end
                OP_UL_FIN: begin
                    r_count          <= r_count - CW'(1);
                    r_active[r_slot] <= 1'b0;
                end
                OP_IN_FIN: begin
                    r_count          <= r_count + CW'(1);
                    r_active[r_slot] <= 1'b1;
                end
                OP_RELOAD: begin
                    r_pend_v    <= 1'b1;
                    r_pend_ev   <= (r_srd_per != 31'd0) ? EV_PERIODIC : EV_ONESHOT;
                    r_pend_slot <= r_slot;
                    r_nres      <= r_nres + 5'd1;
                end
                OP_LOAD_PEND: begin
                    r_pend_v <= 1'b0;
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.op == OP_LOAD_ACK || i_cmd.op == OP_LOAD_REM
                     || i_cmd.op == OP_LOAD_PEND || i_cmd.op == OP_LOAD_IDLE_ACK) begin
            r_ovalid <= 1'b1;
        end else if (out_take) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD_ACK: begin
                r_oev   <= EV_ACK;
                r_oslot <= r_id;
                r_ostat <= i_cmd.err;
                r_orem  <= '0;
                r_olast <= 1'b1;
            end
            OP_LOAD_REM: begin
                r_oev   <= EV_ACK;
                r_oslot <= r_id;
                r_ostat <= ST_OK;
                r_orem  <= (r_active[id_idx] && f_before(r_now, r_srd_exp))
                           ? rem_diff[30:0] : 31'd0;
                r_olast <= 1'b1;
            end
            OP_LOAD_PEND: begin
                r_oev   <= r_pend_ev;
                r_oslot <= 4'(r_pend_slot);
                r_ostat <= ST_OK;
                r_orem  <= '0;
                r_olast <= i_cmd.last;
            end
            OP_LOAD_IDLE_ACK: begin
                r_oev   <= EV_ACK;
                r_oslot <= '0;
                r_ostat <= ST_OK;
                r_orem  <= '0;
                r_olast <= 1'b1;
            end
            default: begin
                r_oev <= r_oev;
            end
        endcase
        if (i_cmd.op == OP_LOAD_ACK || i_cmd.op == OP_LOAD_REM
            || i_cmd.op == OP_LOAD_PEND || i_cmd.op == OP_LOAD_IDLE_ACK) begin
            r_onow  <= r_now;
            r_oidle <= r_idle;
        end
    end

    assign o_res_if.valid      = r_ovalid;
    assign o_res_if.event_res  = r_oev;
    assign o_res_if.slot       = r_oslot;
    assign o_res_if.status     = r_ostat;
    assign o_res_if.remaining  = r_orem;
    assign o_res_if.now_ticks  = r_onow;
    assign o_res_if.idle_total = r_oidle;
    assign o_res_if.last       = r_olast;

    `STQ_ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= CW'(SLOTS), "list count above slot count")
    `STQ_ASSERT_ALWAYS(a_count_active, i_clk, i_rst_n, $countones(r_active) == 32'(r_count), "active flags disagree with list count")
    `STQ_ASSERT_IMPL(a_nres_bound, i_clk, i_rst_n, i_cmd.op == OP_RELOAD, r_nres < MAX_RES_V, "too many expiries in one tick")

endmodule

>>> rtl/stq_ctrl.sv
// Controller state machine that sequences the timer queue datapath.
`timescale 1ns / 1ps
`include "sorted_timer_queue_defines.svh"

module stq_ctrl
    import stq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_sts   i_sts,
    output t_ctrl_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_ins, n_ins;
    logic   r_tick, n_tick;
    logic   r_err, n_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ins   <= 1'b0;
            r_tick  <= 1'b0;
            r_err   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ins   <= n_ins;
            r_tick  <= n_tick;
            r_err   <= n_err;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_ins          = r_ins;
        n_tick         = r_tick;
        n_err          = r_err;
        o_cmd.op       = OP_NONE;
        o_cmd.in_ready = 1'b0;
        o_cmd.err      = r_err;
        o_cmd.last     = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    o_cmd.op = OP_CAPTURE;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                n_tick = 1'b0;
                n_err  = ST_OK;
                n_ins  = 1'b0;
                if (i_sts.cmd == CMD_TICK) begin
                    o_cmd.op = OP_TICK_START;
                    n_tick   = 1'b1;
                    n_state  = S_T_HEAD;
                end else if (i_sts.cmd > CMD_READ || !i_sts.id_ok) begin
                    n_err   = ST_ERR;
                    n_state = S_RESP;
                end else begin
                    case (i_sts.cmd)
                        CMD_ONESHOT: begin
                            o_cmd.op = OP_ARM_SETUP;
                            n_ins    = 1'b1;
                            n_state  = i_sts.active_id ? S_UL_RD : S_IN_INIT;
                        end
                        CMD_PERIODIC: begin
                            if (!i_sts.delay_zero && i_sts.period_zero) begin
                                n_err   = ST_ERR;
                                n_state = S_RESP;
                            end else if (i_sts.delay_zero) begin
                                if (!i_sts.active_id) begin
                                    n_err   = ST_ERR;
                                    n_state = S_RESP;
                                end else begin
                                    o_cmd.op = OP_STOP_SETUP;
                                    n_state  = S_UL_RD;
                                end
                            end else begin
                                o_cmd.op = OP_ARM_SETUP;
                                n_ins    = 1'b1;
                                n_state  = i_sts.active_id ? S_UL_RD : S_IN_INIT;
                            end
                        end
                        CMD_STOP: begin
                            if (i_sts.active_id) begin
                                o_cmd.op = OP_STOP_SETUP;
                                n_state  = S_UL_RD;
                            end else begin
                                n_state = S_RESP;
                            end
                        end
                        default: begin
                            o_cmd.op = OP_READ_SETUP;
                            n_state  = S_RD_REM;
                        end
                    endcase
                end
            end
            S_UL_RD: begin
                if (i_sts.ul_done) begin
                    o_cmd.op = OP_UL_FIN;
                    if (r_ins) begin
                        n_state = S_IN_INIT;
                    end else begin
                        n_state = r_tick ? S_T_HEAD : S_RESP;
                    end
                end else begin
                    o_cmd.op = OP_UL_READ;
                    n_state  = S_UL_CHK;
                end
            end
            S_UL_CHK: begin
                o_cmd.op = OP_UL_STEP;
                n_state  = S_UL_RD;
            end
            S_IN_INIT: begin
                o_cmd.op = OP_IN_START;
                n_state  = S_IN_RD;
            end
            S_IN_RD: begin
                if (i_sts.in_at_head) begin
                    o_cmd.op = OP_IN_FIN;
                    n_state  = r_tick ? S_T_HEAD : S_RESP;
                end else begin
                    o_cmd.op = OP_IN_READ;
                    n_state  = S_IN_CHK;
                end
            end
            S_IN_CHK: begin
                if (i_sts.in_shift) begin
                    o_cmd.op = OP_IN_SHIFT;
                    n_state  = S_IN_RD;
                end else begin
                    o_cmd.op = OP_IN_FIN;
                    n_state  = r_tick ? S_T_HEAD : S_RESP;
                end
            end
            S_RESP: begin
                if (!i_sts.out_full) begin
                    o_cmd.op = OP_LOAD_ACK;
                    n_state  = S_IDLE;
                end
            end
            S_RD_REM: begin
                if (!i_sts.out_full) begin
                    o_cmd.op = OP_LOAD_REM;
                    n_state  = S_IDLE;
                end
            end
            S_T_HEAD: begin
                if (i_sts.count_zero || i_sts.nres_max) begin
                    n_state = S_T_END;
                end else begin
                    o_cmd.op = OP_HEAD_READ;
                    n_state  = S_T_HCHK;
                end
            end
            S_T_HCHK: begin
                n_state = i_sts.head_due ? S_T_FLUSH : S_T_END;
            end
            S_T_FLUSH: begin
                if (!i_sts.pend_v) begin
                    n_state = S_T_TAKE;
                end else if (!i_sts.out_full) begin
                    o_cmd.op   = OP_LOAD_PEND;
                    o_cmd.last = 1'b0;
                    n_state    = S_T_TAKE;
                end
            end
            S_T_TAKE: begin
                o_cmd.op = OP_TAKE;
                n_state  = S_T_RELOAD;
            end
            S_T_RELOAD: begin
                o_cmd.op = OP_RELOAD;
                n_ins    = i_sts.per_nz;
                n_state  = S_UL_RD;
            end
            S_T_END: begin
                if (!i_sts.out_full) begin
                    o_cmd.op = i_sts.pend_v ? OP_LOAD_PEND : OP_LOAD_IDLE_ACK;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `STQ_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, o_cmd.op == OP_LOAD_ACK || o_cmd.op == OP_LOAD_REM || o_cmd.op == OP_LOAD_PEND || o_cmd.op == OP_LOAD_IDLE_ACK, !i_sts.out_full, "result register loaded while full")
    `STQ_ASSERT_IMPL(a_ready_idle, i_clk, i_rst_n, o_cmd.in_ready, r_state == S_IDLE && !r_tick || r_state == S_IDLE, "input taken outside idle")

endmodule

>>> rtl/sorted_timer_queue.sv
// Top level of the sorted timer queue: controller and datapath.
// A command with no list work passes from capture through decode and response back to idle.
// An unlink reads and checks list entries in turn; an insert reads from the tail, shifting entries to its place.
// A tick reads and checks the head; each due timer is flushed, taken, reloaded, unlinked and, if periodic, inserted.
// Throughput: one item at a time; a full result register stalls the controller until taken.
// Reset is synchronous, active low; slot tables need no clearing pass.
`timescale 1ns / 1ps

module sorted_timer_queue
    import stq_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    stq_cmd_if.sink   i_cmd_if,
    stq_res_if.source o_res_if
);

    t_ctrl_cmd ctrl_cmd;
    t_dp_sts   dp_sts;

    stq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (dp_sts),
        .o_cmd   (ctrl_cmd)
    );

    stq_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (ctrl_cmd),
        .o_sts    (dp_sts),
        .i_cmd_if (i_cmd_if),
        .o_res_if (o_res_if)
    );

endmodule

>>> dv/stq_tb_if.sv
// Testbench file with no declarations; the command and result handshake interfaces come from rtl/stq_if.sv.
`timescale 1ns / 1ps

>>> dv/sorted_timer_queue_checker.sv
// Checker that predicts the timer queue results from observed command transfers and compares them.
`timescale 1ns / 1ps

module sorted_timer_queue_checker
    import stq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    stq_cmd_if      cmd_mon,
    stq_res_if      res_mon,
    output int      o_fail_count,
    output int      o_pending
);

    typedef struct packed {
        logic [1:0]  event_res;
        logic [3:0]  slot;
        logic        status;
        logic [30:0] remaining;
        logic [31:0] now_ticks;
        logic [31:0] idle_total;
        logic        last;
    } t_timer_result;

    localparam int NSLOT = 16;

    logic [31:0] tick_now;
    logic [31:0] tick_idle;
    logic [31:0] due_at [NSLOT];
    logic [31:0] reload [NSLOT];
    logic        armed [NSLOT];
    int          due_order [$];
    t_timer_result expected_results [$];

    function automatic logic is_earlier(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    function automatic void drop_slot(int s);
        int pos;
        if (!armed[s]) return;
        pos = -1;
        foreach (due_order[k]) if (due_order[k] == s && pos < 0) pos = k;
        if (pos >= 0) due_order.delete(pos);
        armed[s] = 1'b0;
    endfunction

    function automatic void schedule_slot(int s, logic [31:0] ticks);
        logic [31:0] e;
        int pos;
        if (ticks == 0) ticks = 1;
        e = tick_now + ticks;
        due_at[s] = e;
        pos = due_order.size();
        for (int k = due_order.size() - 1; k >= 0; k--)
            if (is_earlier(e, due_at[due_order[k]])) pos = k;
        if (due_order.size() >= NSLOT) return;
        due_order.insert(pos, s);
        armed[s] = 1'b1;
    endfunction

    function automatic void push_result(logic [1:0] ev, int s, logic st, logic [30:0] rem,
                                        logic lst);
        t_timer_result r;
        r.event_res = ev;
        r.slot = 4'(s);
        r.status = st;
        r.remaining = rem;
        r.now_ticks = tick_now;
        r.idle_total = tick_idle;
        r.last = lst;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_command(logic [2:0] cmd, logic [3:0] id, logic [30:0] dly,
                                            logic [30:0] per, logic idl);
        t_timer_result batch [$];
        logic        st;
        logic [30:0] rem;
        logic [31:0] e, ne, t;
        int s;
        st = ST_OK;
        rem = '0;
        if (cmd == CMD_TICK) begin
            tick_now++;
            if (idl) tick_idle++;
            while (due_order.size() > 0 && batch.size() < MAX_RES) begin
                t_timer_result r;
                s = due_order[0];
                e = due_at[s];
                if (is_earlier(tick_now, e)) break;
                drop_slot(s);
                r = '0;
                r.slot = 4'(s);
                r.now_ticks = tick_now;
                r.idle_total = tick_idle;
                if (reload[s] != 0) begin
                    ne = e + reload[s];
                    t = is_earlier(tick_now, ne) ? ne - tick_now : 32'd0;
                    schedule_slot(s, t);
                    r.event_res = EV_PERIODIC;
                end else begin
                    r.event_res = EV_ONESHOT;
                end
                batch.push_back(r);
            end
            if (batch.size() == 0) begin
                push_result(EV_ACK, 0, ST_OK, '0, 1'b1);
            end else begin
                batch[batch.size() - 1].last = 1'b1;
                foreach (batch[k]) expected_results.push_back(batch[k]);
            end
            return;
        end
        if (cmd > CMD_READ) begin
            st = ST_ERR;
        end else if (cmd == CMD_ONESHOT) begin
            drop_slot(id);
            reload[id] = '0;
            schedule_slot(id, {1'b0, dly});
        end else if (cmd == CMD_PERIODIC) begin
            if (dly != 0 && per == 0) begin
                st = ST_ERR;
            end else if (dly == 0) begin
                if (!armed[id]) st = ST_ERR;
                else drop_slot(id);
            end else begin
                drop_slot(id);
                reload[id] = {1'b0, per};
                schedule_slot(id, {1'b0, dly});
            end
        end else if (cmd == CMD_STOP) begin
            drop_slot(id);
        end else begin
            if (armed[id] && is_earlier(tick_now, due_at[id])) rem = 31'(due_at[id] - tick_now);
        end
        push_result(EV_ACK, id, st, rem, 1'b1);
    endfunction

    task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_timer_result exp_r;
        if (!i_rst_n) begin
            tick_now = '0;
            tick_idle = '0;
            for (int k = 0; k < NSLOT; k++) armed[k] = 1'b0;
            due_order.delete();
            expected_results.delete();
            o_fail_count = 0;
        end else begin
            if (res_mon.valid && res_mon.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no expected result, slot %0d", res_mon.slot);
                    o_fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    compare_field("event_res", exp_r.event_res, res_mon.event_res);
                    compare_field("slot", exp_r.slot, res_mon.slot);
                    compare_field("status", exp_r.status, res_mon.status);
                    compare_field("remaining", exp_r.remaining, res_mon.remaining);
                    compare_field("now_ticks", exp_r.now_ticks, res_mon.now_ticks);
                    compare_field("idle_total", exp_r.idle_total, res_mon.idle_total);
                    compare_field("last", exp_r.last, res_mon.last);
                end
            end
            if (cmd_mon.valid && cmd_mon.ready)
                predict_command(cmd_mon.command, cmd_mon.timer_id, cmd_mon.delay,
                                cmd_mon.period, cmd_mon.idle);
        end
        o_pending = expected_results.size();
    end

endmodule

>>> dv/sorted_timer_queue_tb.sv
// Top of the timer queue testbench: clock, reset, command stimulus, result back-pressure, verdict.
`timescale 1ns / 1ps

module sorted_timer_queue_tb;
    import stq_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   send_idle_pct;
    int   recv_idle_pct;
    logic recv_hold;
    int   quiet_cycles;

    stq_cmd_if cmd_if ();
    stq_res_if res_if ();

    sorted_timer_queue DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd_if (cmd_if.sink),
        .o_res_if (res_if.source)
    );

    sorted_timer_queue_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .cmd_mon      (cmd_if),
        .res_mon      (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    initial begin
        i_rst_n = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.command = CMD_TICK;
        cmd_if.timer_id = '0;
        cmd_if.delay = '0;
        cmd_if.period = '0;
        cmd_if.idle = 1'b0;
        res_if.ready = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || recv_hold) res_if.ready <= 1'b0;
        else res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("sorted_timer_queue_tb: errors");
            $finish;
        end
    end

    task automatic send_command(logic [2:0] cmd, logic [3:0] id, logic [30:0] dly,
                                logic [30:0] per, logic idl);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.command <= cmd;
        cmd_if.timer_id <= id;
        cmd_if.delay <= dly;
        cmd_if.period <= per;
        cmd_if.idle <= idl;
        do @(posedge i_clk); while (!cmd_if.ready);
    endtask

    task automatic send_random_command();
        int pick;
        logic [30:0] dly;
        logic [30:0] per;
        pick = $urandom_range(99);
        dly = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(6));
        per = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(5));
        if (pick < 45) send_command(CMD_TICK, 4'($urandom), dly, per, 1'($urandom));
        else if (pick < 60) send_command(CMD_ONESHOT, 4'($urandom), dly, per, 1'($urandom));
        else if (pick < 78) send_command(CMD_PERIODIC, 4'($urandom), dly, per, 1'($urandom));
        else if (pick < 86) send_command(CMD_STOP, 4'($urandom), dly, per, 1'($urandom));
        else if (pick < 97) send_command(CMD_READ, 4'($urandom), dly, per, 1'($urandom));
        else send_command(3'($urandom_range(7, 5)), 4'($urandom), dly, per, 1'($urandom));
    endtask

    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 9;
        recv_idle_pct = 75;

        send_command(CMD_TICK, 4'd0, '0, '0, 1'b1);
        send_command(CMD_READ, 4'd3, '0, '0, 1'b0);
        send_command(CMD_STOP, 4'd3, '0, '0, 1'b0);
        send_command(CMD_PERIODIC, 4'd3, '0, '0, 1'b0);
        send_command(CMD_PERIODIC, 4'd4, 31'd5, '0, 1'b0);
        send_command(CMD_ONESHOT, 4'd1, '0, '1, 1'b0);
        send_command(CMD_ONESHOT, 4'd2, 31'd1, '0, 1'b0);
        send_command(CMD_PERIODIC, 4'd15, 31'd1, 31'd1, 1'b0);
        send_command(CMD_ONESHOT, 4'd7, '1, '1, 1'b1);
        send_command(CMD_PERIODIC, 4'd8, 31'h40000000, '1, 1'b0);
        send_command(CMD_READ, 4'd7, '0, '0, 1'b0);
        send_command(CMD_ONESHOT, 4'd2, 31'd2, '0, 1'b0);
        send_command(CMD_TICK, 4'd0, '0, '0, 1'b0);
        send_command(CMD_TICK, 4'd0, '0, '0, 1'b1);
        send_command(3'd5, 4'd1, '0, '0, 1'b0);
        send_command(3'd7, 4'hf, '1, '1, 1'b1);
        send_command(CMD_PERIODIC, 4'd15, '0, '0, 1'b0);
        send_command(CMD_STOP, 4'd7, '0, '0, 1'b0);
        send_command(CMD_READ, 4'd8, '0, '0, 1'b0);
        wait_drained();

        for (int k = 0; k < 16; k++) send_command(CMD_PERIODIC, 4'(k), 31'd3, 31'd2, 1'b0);
        recv_hold = 1'b1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            for (int k = 0; k < 6; k++) send_command(CMD_TICK, '0, '0, '0, 1'b1);
        join
        wait_drained();

        for (int n = 0; n < 140; n++) send_random_command();
        wait_drained();
        send_idle_pct = 75;
        recv_idle_pct = 9;
        for (int n = 0; n < 130; n++) send_random_command();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int n = 0; n < 120; n++) send_random_command();
        wait_drained();
        repeat (100) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("sorted_timer_queue_tb: clean");
        end else begin
            $display("sorted_timer_queue_tb: errors");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/stq_pkg.sv
rtl/stq_if.sv
rtl/stq_datapath.sv
rtl/stq_ctrl.sv
rtl/sorted_timer_queue.sv
dv/stq_tb_if.sv
dv/sorted_timer_queue_checker.sv
dv/sorted_timer_queue_tb.sv
